FILE: hdl/stq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types, widths and codes of the sorted timer event queue.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int TIME_W  = 64;
    localparam int DELAY_W = 16;
    localparam int TAG_W   = 16;
    localparam int TPS_W   = 32;
    localparam int KIND_W  = 2;
    localparam int PROD_W  = DELAY_W + TPS_W;

    localparam int QUEUE_DEPTH = 16;

    localparam logic [TPS_W-1:0] RESET_TPS = 32'hFFFF_FFFF;

    // operation codes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ACCEPT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DONE    = 2'd3;

    typedef struct packed {
        logic               operation;
        logic [TIME_W-1:0]  now;
        logic [DELAY_W-1:0] delay_seconds;
        logic [TAG_W-1:0]   event_tag;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TAG_W-1:0]   expired_tag;
        logic               set_deadline;
        logic [TIME_W-1:0]  deadline;
        logic               last;
    } t_res;

    typedef struct packed {
        logic [TIME_W-1:0] expiry;
        logic [TAG_W-1:0]  tag;
    } t_entry;

endpackage

FILE: hdl/stq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/stq_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_alu
// Shared time unit: builds the search key (expiry for an add, now for a
// tick) and compares a stored expiry against it.
// ----------------------------------------------------------------------------
module stq_alu (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  stq_pkg::t_cmd               i_cmd,
    input  logic [stq_pkg::TPS_W-1:0]   i_tps,
    input  logic [stq_pkg::TIME_W-1:0]  i_entry_time,
    output logic [stq_pkg::TIME_W-1:0]  o_key,
    output logic                        o_le
);

    logic                         r_op;
    logic [stq_pkg::TIME_W-1:0]   r_now;
    logic [stq_pkg::DELAY_W-1:0]  r_delay;
    logic [stq_pkg::PROD_W-1:0]   r_prod;
    logic [stq_pkg::TIME_W-1:0]   r_key;

    // capture the command, then multiply, then add: the key is registered
    // after the product and holds until the next load
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_op    <= i_cmd.operation;
            r_now   <= i_cmd.now;
            r_delay <= i_cmd.delay_seconds;
        end
        r_prod <= stq_pkg::PROD_W'(r_delay) * stq_pkg::PROD_W'(i_tps);
        if (r_op == stq_pkg::OP_TICK) begin
            r_key <= r_now;
        end else begin
            r_key <= r_now + stq_pkg::TIME_W'(r_prod);
        end
    end

    assign o_key = r_key;
    assign o_le  = (i_entry_time <= r_key);

endmodule

FILE: hdl/sorted_timer_event_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_event_queue_top
// Bounded table of timer events kept sorted by 64-bit expiry time.
// ----------------------------------------------------------------------------
// Usage: drive a command word on i_cmd and raise start while busy is low.
// Each result word appears on o_res for exactly one cycle with o_res_valid
// high; the receiver cannot stall, so capture it on that cycle. The final
// word of each command carries last = 1, and busy is low again in the cycle
// that word is shown, so the next command may be issued right then.
// Sequence: an add to a full table is answered from the idle state with
// no search. Any other add walks down from the tail past each stored entry
// with a later expiry; every step is a RAM read followed by a compare and
// a RAM write, and an add that reaches the head is placed there with no
// compare. A tick pops expired entries from the head, one RAM read plus
// one compare per pop. States S_MUL and S_KEY at the start of every
// non-full command build the key in the multiply-add stage.
// ticks_per_second is written through the config channel, which is always
// ready; write it only while busy is low and no result is pending.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue_top #(
    parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // command channel
    input  logic                       start,
    output logic                       busy,
    input  stq_pkg::t_cmd              i_cmd,
    // result channel
    output logic                       o_res_valid,
    output stq_pkg::t_res              o_res,
    // config channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [stq_pkg::TPS_W-1:0]  i_cfg_data
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int EW = $bits(stq_pkg::t_entry);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;  // product forms
    localparam logic [2:0] S_KEY  = 3'd2;  // key forms
    localparam logic [2:0] S_ARD  = 3'd3;  // add: read entry before the hole
    localparam logic [2:0] S_ACMP = 3'd4;  // add: compare, shift or place
    localparam logic [2:0] S_TRD  = 3'd5;  // tick: read head
    localparam logic [2:0] S_TCMP = 3'd6;  // tick: compare, pop or finish

    // map a logical position to a RAM address in the circular table
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] base,
                                             input logic [CW-1:0] ofs);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(ofs);
        if (sum >= SW'(QUEUE_DEPTH)) begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [2:0]                 r_state, n_state;
    logic [CW-1:0]              r_count, n_count;
    logic [AW-1:0]              r_head,  n_head;
    logic [CW-1:0]              r_idx,   n_idx;     // hole position on add
    logic                       r_op;
    logic [stq_pkg::TAG_W-1:0]  r_tag;
    logic [stq_pkg::TPS_W-1:0]  r_tps;
    logic                       r_res_valid, n_res_valid;
    stq_pkg::t_res              r_res, n_res;

    logic                       accept;
    logic                       full;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [AW-1:0]              ram_raddr;
    stq_pkg::t_entry            ram_wdata;
    stq_pkg::t_entry            ram_rdata;
    logic [EW-1:0]              ram_rdata_bits;
    logic [stq_pkg::TIME_W-1:0] key;
    logic                       entry_le;
    logic [SW-1:0]              head_inc;

    assign accept    = start && !busy;
    assign full      = (r_count == CW'(QUEUE_DEPTH));
    assign ram_rdata = stq_pkg::t_entry'(ram_rdata_bits);
    assign head_inc  = SW'(r_head) + SW'(1);

    stq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_bits)
    );

    stq_alu u_alu (
        .i_clk        (i_clk),
        .i_load       (accept),
        .i_cmd        (i_cmd),
        .i_tps        (r_tps),
        .i_entry_time (ram_rdata.expiry),
        .o_key        (key),
        .o_le         (entry_le)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_idx       = r_idx;
        n_res_valid = 1'b0;
        n_res       = r_res;
        ram_we      = 1'b0;
        ram_waddr   = f_phys(r_head, r_idx);
        ram_wdata   = '{expiry: key, tag: r_tag};
        ram_raddr   = f_phys(r_head, r_idx - CW'(1));

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd.operation == stq_pkg::OP_ADD && full) begin
                        // reject at once, table untouched
                        n_res_valid = 1'b1;
                        n_res = '{kind: stq_pkg::KIND_FULL, expired_tag: '0,
                                  set_deadline: 1'b0, deadline: '0, last: 1'b1};
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_state = S_KEY;
            end
            S_KEY: begin
                n_idx   = r_count;
                n_state = (r_op == stq_pkg::OP_TICK) ? S_TRD : S_ARD;
            end
            S_ARD: begin
                if (r_idx == '0) begin
                    // hole reached the head: place here, new head deadline
                    ram_we      = 1'b1;
                    n_count     = r_count + CW'(1);
                    n_res_valid = 1'b1;
                    n_res = '{kind: stq_pkg::KIND_ACCEPT, expired_tag: '0,
                              set_deadline: 1'b1, deadline: key, last: 1'b1};
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_ACMP;
                end
            end
            S_ACMP: begin
                ram_we = 1'b1;
                if (!entry_le) begin
                    // later expiry: move it up one slot, advance hole down
                    ram_wdata = ram_rdata;
                    n_idx     = r_idx - CW'(1);
                    n_state   = S_ARD;
                end else begin
                    // equal or earlier: new event goes after it
                    n_count     = r_count + CW'(1);
                    n_res_valid = 1'b1;
                    n_res = '{kind: stq_pkg::KIND_ACCEPT, expired_tag: '0,
                              set_deadline: 1'b0, deadline: '0, last: 1'b1};
                    n_state     = S_IDLE;
                end
            end
            S_TRD: begin
                ram_raddr = r_head;
                if (r_count == '0) begin
                    n_res_valid = 1'b1;
                    n_res = '{kind: stq_pkg::KIND_DONE, expired_tag: '0,
                              set_deadline: 1'b0, deadline: '0, last: 1'b1};
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_TCMP;
                end
            end
            S_TCMP: begin
                ram_raddr   = r_head;
                n_res_valid = 1'b1;
                if (entry_le) begin
                    // pop the head and report it
                    n_res = '{kind: stq_pkg::KIND_EXPIRED, expired_tag: ram_rdata.tag,
                              set_deadline: 1'b0, deadline: '0, last: 1'b0};
                    n_count = r_count - CW'(1);
                    n_head  = (head_inc == SW'(QUEUE_DEPTH)) ? '0 : head_inc[AW-1:0];
                    n_state = S_TRD;
                end else begin
                    n_res = '{kind: stq_pkg::KIND_DONE, expired_tag: '0,
                              set_deadline: 1'b1, deadline: ram_rdata.expiry,
                              last: 1'b1};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_res_valid <= 1'b0;
            r_tps       <= stq_pkg::RESET_TPS;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_res_valid <= n_res_valid;
            if (i_cfg_valid) begin
                r_tps <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_res <= n_res;
        if (accept) begin
            r_op  <= i_cmd.operation;
            r_tag <= i_cmd.event_tag;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

endmodule
